// File: design/assert_macros.svh
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gmt check failed");

// next-cycle implication
`define GMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gmt check failed");

`endif

// File: design/gmt_pkg.sv
// gmt_pkg: widths, register codes and shared types of the edge map block
// no dependencies
`default_nettype none

package gmt_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 9;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIFF_W     = 9;
  localparam int SQ_W       = 16;
  localparam int LIM_W      = 20;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             restart;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } gmt_geom_t;

  typedef struct packed {
    logic                     has_edge;
    logic                     interior;
    logic                     last_row;
    logic                     last_col;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } gmt_entry_t;

endpackage

`default_nettype wire

// File: design/gmt_if.sv
// gmt_pix_if and gmt_res_if: valid/ready channels for pixels and results
// depends on gmt_pkg
`default_nettype none

interface gmt_pix_if;
  logic                      valid;
  logic                      ready;
  logic [gmt_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface gmt_res_if;
  logic                      valid;
  logic                      ready;
  logic [gmt_pkg::PIX_W-1:0] edge_value;
  logic                      last_of_run;
  logic                      frame_done;
  modport source (output valid, output edge_value, output last_of_run, output frame_done,
                  input ready);
  modport sink (input valid, input edge_value, input last_of_run, input frame_done,
                output ready);
endinterface

`default_nettype wire

// File: design/gmt_front.sv
// gmt_front: pixel intake, raster position, line stores and middle-row taps
// pushes one entry per pixel that causes results; depends on gmt_pkg, gmt_if
`default_nettype none

module gmt_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gmt_pix_if.sink             pix_i,
  input  gmt_pkg::gmt_geom_t  geom_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output gmt_pkg::gmt_entry_t q_entry_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > gmt_pkg::DIM_W) ? CW + 1 : gmt_pkg::DIM_W;
  localparam int HW = (RW + 1 > gmt_pkg::DIM_W) ? RW + 1 : gmt_pkg::DIM_W;

  logic [WW-1:0] w_ext, w_last_ext;
  logic [HW-1:0] h_ext, h_last_ext;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          accept;

  logic                      s1_valid_q;
  logic [gmt_pkg::PIX_W-1:0] s1_px_q;
  logic [CW-1:0]             s1_col_q;
  logic                      s1_c0_q, s1_right_q, s1_has_edge_q, s1_interior_q;
  logic                      s1_last_row_q, s1_last_col_q;
  logic                      s1_emit, s1_go;

  logic [gmt_pkg::PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [gmt_pkg::PIX_W-1:0] old_mem [MAX_WIDTH];
  logic [gmt_pkg::PIX_W-1:0] mid_rd_q, old_rd_q, fc_q;
  logic [CW-1:0]             mid_raddr;

  logic [gmt_pkg::PIX_W-1:0] t0_q, t1_q, t2_q, t0_d, t1_d, t2_d;

  // clamp geometry to 1..max
  always_comb begin
    w_ext = WW'(geom_i.width);
    if (w_ext == '0) begin
      w_last_ext = '0;
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_last_ext = WW'(MAX_WIDTH - 1);
    end else begin
      w_last_ext = w_ext - WW'(1);
    end
    h_ext = HW'(geom_i.height);
    if (h_ext == '0) begin
      h_last_ext = '0;
    end else if (h_ext > HW'(MAX_HEIGHT)) begin
      h_last_ext = HW'(MAX_HEIGHT - 1);
    end else begin
      h_last_ext = h_ext - HW'(1);
    end
  end

  assign w_last = w_last_ext[CW-1:0];
  assign h_last = h_last_ext[RW-1:0];

  assign s1_emit     = s1_has_edge_q || s1_last_row_q;
  assign s1_go       = s1_valid_q && (!s1_emit || q_ready_i);
  assign pix_i.ready = !s1_valid_q || s1_go;
  assign accept      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (geom_i.restart) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (col_q == w_last) begin
          col_q <= '0;
          row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q       <= pix_i.pixel;
      s1_col_q      <= col_q;
      s1_c0_q       <= (col_q == '0);
      s1_right_q    <= (col_q != w_last);
      s1_has_edge_q <= (row_q != '0);
      s1_interior_q <= (row_q > RW'(1)) && (col_q != '0) && (col_q != w_last);
      s1_last_row_q <= (row_q == h_last);
      s1_last_col_q <= (col_q == w_last);
    end
  end

  // shift the middle-row window
  always_comb begin
    t0_d = s1_c0_q ? '0 : t1_q;
    t1_d = s1_c0_q ? fc_q : t2_q;
    t2_d = s1_right_q ? mid_rd_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q <= '0;
      t1_q <= '0;
      t2_q <= '0;
    end else if (s1_go) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
  end

  assign mid_raddr = col_q + CW'(1);

  // line stores, with bypass of the write at the same edge
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      mid_mem[s1_col_q] <= s1_px_q;
      old_mem[s1_col_q] <= t1_d;
      if (s1_c0_q) begin
        fc_q <= s1_px_q;
      end
    end
    if (accept) begin
      mid_rd_q <= (s1_go && s1_col_q == mid_raddr) ? s1_px_q : mid_mem[mid_raddr];
      old_rd_q <= (s1_go && s1_col_q == col_q) ? t1_d : old_mem[col_q];
    end
  end

  always_comb begin
    q_entry_o.has_edge = s1_has_edge_q;
    q_entry_o.interior = s1_interior_q;
    q_entry_o.last_row = s1_last_row_q;
    q_entry_o.last_col = s1_last_col_q;
    q_entry_o.dx = $signed({1'b0, s1_px_q}) - $signed({1'b0, old_rd_q});
    q_entry_o.dy = $signed({1'b0, t2_d}) - $signed({1'b0, t0_d});
  end

  assign q_push_o = s1_go && s1_emit;

endmodule

`default_nettype wire

// File: design/gmt_queue.sv
// gmt_queue: short fifo of classified entries between front and back
// depends on gmt_pkg
`default_nettype none

module gmt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gmt_pkg::gmt_entry_t entry_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output gmt_pkg::gmt_entry_t entry_o
);

  gmt_pkg::gmt_entry_t              slot_q [gmt_pkg::QDEPTH];
  logic [gmt_pkg::QPTR_W-1:0]       wr_q, rd_q;
  logic [gmt_pkg::QPTR_W:0]         cnt_q;
  logic                             do_push, do_pop;

  assign ready_o = (cnt_q != (gmt_pkg::QPTR_W + 1)'(gmt_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + gmt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + gmt_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (gmt_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (gmt_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// File: design/gmt_back.sv
// gmt_back: squares, threshold compare and result sequencing
// one or two results per entry through a single output register; depends on gmt_pkg, gmt_if
`default_nettype none

module gmt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gmt_pkg::THR_W-1:0] threshold_i,
  input  logic                      q_valid_i,
  input  gmt_pkg::gmt_entry_t       q_entry_i,
  output logic                      q_pop_o,
  gmt_res_if.source                 res_o
);

  logic [gmt_pkg::THR_W:0]   thr_p1;
  logic [gmt_pkg::LIM_W-1:0] thr_ext, lim_q;

  logic signed [2*gmt_pkg::DIFF_W-1:0] dx2, dy2;

  logic                     b1_valid_q, b1_phase_q;
  logic [gmt_pkg::SQ_W-1:0] b1_sq0_q, b1_sq1_q;
  logic                     b1_has_edge_q, b1_interior_q, b1_last_row_q, b1_last_col_q;
  logic                     b1_first, b1_done, b1_take, out_load, edge_hit;
  logic [gmt_pkg::SQ_W:0]   sum;

  logic                      out_valid_q;
  logic [gmt_pkg::PIX_W-1:0] out_edge_q;
  logic                      out_last_q, out_done_q;

  assign thr_p1  = (gmt_pkg::THR_W + 1)'(threshold_i) + (gmt_pkg::THR_W + 1)'(1);
  assign thr_ext = gmt_pkg::LIM_W'(thr_p1);

  always_ff @(posedge clk_i) begin
    lim_q <= thr_ext * thr_ext;
  end

  assign dx2 = q_entry_i.dx * q_entry_i.dx;
  assign dy2 = q_entry_i.dy * q_entry_i.dy;

  assign out_load = b1_valid_q && (!out_valid_q || res_o.ready);
  assign b1_first = b1_has_edge_q && !b1_phase_q;
  assign b1_done  = out_load && !(b1_first && b1_last_row_q);
  assign b1_take  = !b1_valid_q || b1_done;
  assign q_pop_o  = b1_take && q_valid_i;

  assign sum      = (gmt_pkg::SQ_W + 1)'(b1_sq0_q) + (gmt_pkg::SQ_W + 1)'(b1_sq1_q);
  assign edge_hit = b1_interior_q && (gmt_pkg::LIM_W'(sum) >= lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b1_phase_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_take) begin
        b1_valid_q <= q_valid_i;
        b1_phase_q <= 1'b0;
      end else if (out_load) begin
        b1_phase_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b1_sq0_q      <= dx2[gmt_pkg::SQ_W-1:0];
      b1_sq1_q      <= dy2[gmt_pkg::SQ_W-1:0];
      b1_has_edge_q <= q_entry_i.has_edge;
      b1_interior_q <= q_entry_i.interior;
      b1_last_row_q <= q_entry_i.last_row;
      b1_last_col_q <= q_entry_i.last_col;
    end
    if (out_load) begin
      if (b1_first) begin
        out_edge_q <= edge_hit ? gmt_pkg::EDGE_ON : gmt_pkg::EDGE_OFF;
        out_last_q <= !b1_last_row_q;
        out_done_q <= 1'b0;
      end else begin
        // border pixel of the last row
        out_edge_q <= gmt_pkg::EDGE_OFF;
        out_last_q <= 1'b1;
        out_done_q <= b1_last_col_q;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.edge_value  = out_edge_q;
  assign res_o.last_of_run = out_last_q;
  assign res_o.frame_done  = out_done_q;

endmodule

`default_nettype wire

// File: design/gradient_magnitude_threshold.sv
// path: a result passes the intake stage with its line store read, the queue, the square
// stage and the output register before it is offered; a stalled result channel can hold it
// throughput: one pixel per cycle while the queue and result channel do not stall; on the
// last row two results per pixel share the output register
// reset: position counters and handshake state cleared, registers at defaults; line stores
// are not cleared and need no clearing pass
`default_nettype none

module gradient_magnitude_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gmt_pix_if.sink                        pix_i,
  gmt_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [gmt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [gmt_pkg::THR_W-1:0] thr_q;
  logic [gmt_pkg::DIM_W-1:0] width_q, height_q;
  gmt_pkg::gmt_geom_t        geom;
  logic                      q_push, q_ready, q_pop, q_valid;
  gmt_pkg::gmt_entry_t       q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      width_q  <= gmt_pkg::DIM_RESET;
      height_q <= gmt_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gmt_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[gmt_pkg::THR_W-1:0];
        gmt_pkg::CFG_WIDTH:     width_q  <= cfg_data_i[gmt_pkg::DIM_W-1:0];
        gmt_pkg::CFG_HEIGHT:    height_q <= cfg_data_i[gmt_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry writes restart the frame
  assign geom.restart = cfg_we_i && ((cfg_index_i == gmt_pkg::CFG_WIDTH) ||
                                     (cfg_index_i == gmt_pkg::CFG_HEIGHT));
  assign geom.width   = width_q;
  assign geom.height  = height_q;

  gmt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .geom_i    (geom),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  gmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  gmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: design/gmt_checker.sv
// gmt_checker: port-level assertions on the result channel, bound to the top level
// depends on gmt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gmt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [gmt_pkg::PIX_W-1:0] edge_value_i,
  input logic                      last_of_run_i,
  input logic                      frame_done_i
);

  // a stalled transfer keeps its payload
  `GMT_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(edge_value_i) && $stable(last_of_run_i) && $stable(frame_done_i))

  `GMT_ASSERT_IMP(a_edge_binary, res_valid_i, edge_value_i == gmt_pkg::EDGE_ON || edge_value_i == gmt_pkg::EDGE_OFF)

  // end of frame is always a border result closing its run
  `GMT_ASSERT_IMP(a_frame_end, res_valid_i && frame_done_i, last_of_run_i && edge_value_i == gmt_pkg::EDGE_OFF)

endmodule

bind gradient_magnitude_threshold gmt_checker u_gmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .edge_value_i  (res_o.edge_value),
  .last_of_run_i (res_o.last_of_run),
  .frame_done_i  (res_o.frame_done)
);

`default_nettype wire
